// File: hw/rtl/invariant_precondition_conflict_check_assert.svh
// -----------------------------------------------------------------------------
// invariant_precondition_conflict_check_assert.svh
// Assertion macros shared by the conflict check checker.
// -----------------------------------------------------------------------------
`ifndef INVARIANT_PRECONDITION_CONFLICT_CHECK_ASSERT_SVH
`define INVARIANT_PRECONDITION_CONFLICT_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPCC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipcc assertion failed");

// Next-cycle implication that also holds across reset.
`define IPCC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ipcc assertion failed");

`endif

// File: hw/rtl/ipcc_pkg.sv
// -----------------------------------------------------------------------------
// ipcc_pkg
// Shared widths, codes, types and literal helpers of the conflict check.
// -----------------------------------------------------------------------------
package ipcc_pkg;

    localparam int ACT_W = 2;
    localparam int IDX_W = 12;
    localparam int LIT_W = 11;
    localparam int VAR_W = 10;

    localparam int DEF_NUM_VARS       = 1024;
    localparam int DEF_NUM_INVARIANTS = 4096;

    // Item kinds; the fourth code is unused and ignored.
    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_PRECOND = 2'd1,
        ACT_EMPTY   = 2'd2
    } action_t;

    // Work pending behind a bitmap clearing pass.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PRE,
        OP_EMPTY
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SET_PRE,
        ST_SCAN,
        ST_INF_RD,
        ST_INF_WR,
        ST_FINISH,
        ST_RESULT
    } state_t;

    // One invariant: clause "lit_a or lit_b" plus a deleted mark.
    typedef struct packed {
        logic [LIT_W-1:0] lit_a;
        logic [LIT_W-1:0] lit_b;
        logic             dead;
    } tbl_entry_t;

    // Current table entry as seen by the sequencer.
    typedef struct packed {
        logic             match_a;
        logic             match_b;
        logic [LIT_W-1:0] lit_a;
        logic [LIT_W-1:0] lit_b;
    } tbl_view_t;

    // Bitmap port requests from the sequencer.
    typedef struct packed {
        logic [VAR_W-1:0] rd_addr;
        logic [VAR_W-1:0] wr_addr;
        logic             wr_true;
        logic             wr_false;
        logic             wr_val;
    } bm_req_t;

    function automatic logic lit_neg(input logic [LIT_W-1:0] raw);
        lit_neg = raw[LIT_W-1];
    endfunction

    // Negative literal v stands for variable -v-1, which is the low bits inverted.
    function automatic logic [VAR_W-1:0] lit_var(input logic [LIT_W-1:0] raw);
        lit_var = raw[LIT_W-1] ? ~raw[VAR_W-1:0] : raw[VAR_W-1:0];
    endfunction

endpackage

// File: hw/rtl/ipcc_table.sv
// -----------------------------------------------------------------------------
// ipcc_table
// Invariant table memory with registered read and the literal match compare.
// -----------------------------------------------------------------------------
module ipcc_table
    import ipcc_pkg::*;
#(
    parameter int NUM_INVARIANTS = DEF_NUM_INVARIANTS
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  tbl_entry_t       wr_entry,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic [VAR_W-1:0] pre_var,
    output tbl_view_t        view
);

    localparam int TBL_DEPTH = (NUM_INVARIANTS < (1 << IDX_W)) ? NUM_INVARIANTS
                                                              : (1 << IDX_W);
    localparam int TAW       = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    tbl_entry_t mem [TBL_DEPTH];
    tbl_entry_t rd_q_reg;

    // Write in-range slots, read one entry per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en && (32'(wr_idx) < NUM_INVARIANTS)) begin
            mem[wr_idx[TAW-1:0]] <= wr_entry;
        end
        rd_q_reg <= mem[rd_idx[TAW-1:0]];
    end

    // Match a live entry whose literal is the negation of the precondition.
    always_comb begin
        view.lit_a   = rd_q_reg.lit_a;
        view.lit_b   = rd_q_reg.lit_b;
        view.match_a = !rd_q_reg.dead && lit_neg(rd_q_reg.lit_a)
                       && (lit_var(rd_q_reg.lit_a) == pre_var);
        view.match_b = !rd_q_reg.dead && lit_neg(rd_q_reg.lit_b)
                       && (lit_var(rd_q_reg.lit_b) == pre_var);
    end

endmodule

// File: hw/rtl/ipcc_bitmap.sv
// -----------------------------------------------------------------------------
// ipcc_bitmap
// Inferred-true and inferred-false bitmaps, one bit per variable.
// -----------------------------------------------------------------------------
module ipcc_bitmap
    import ipcc_pkg::*;
#(
    parameter int NUM_VARS = DEF_NUM_VARS
) (
    input  logic    aclk,
    input  bm_req_t req,
    output logic    true_q,
    output logic    false_q
);

    localparam int BMP_DEPTH = (NUM_VARS < (1 << VAR_W)) ? NUM_VARS : (1 << VAR_W);
    localparam int BAW       = $clog2(BMP_DEPTH);

    logic true_mem  [BMP_DEPTH];
    logic false_mem [BMP_DEPTH];
    logic true_q_reg;
    logic false_q_reg;

    // One write port per bitmap, shared registered read address.
    always_ff @(posedge aclk) begin
        if (req.wr_true) begin
            true_mem[req.wr_addr[BAW-1:0]] <= req.wr_val;
        end
        if (req.wr_false) begin
            false_mem[req.wr_addr[BAW-1:0]] <= req.wr_val;
        end
        true_q_reg  <= true_mem[req.rd_addr[BAW-1:0]];
        false_q_reg <= false_mem[req.rd_addr[BAW-1:0]];
    end

    assign true_q  = true_q_reg;
    assign false_q = false_q_reg;

endmodule

// File: hw/rtl/ipcc_seq.sv
// -----------------------------------------------------------------------------
// ipcc_seq
// Sequencer: clearing pass, table scan, inference read-modify-write, result.
// -----------------------------------------------------------------------------
module ipcc_seq
    import ipcc_pkg::*;
#(
    parameter int NUM_VARS       = DEF_NUM_VARS,
    parameter int NUM_INVARIANTS = DEF_NUM_INVARIANTS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ACT_W-1:0] s_action,
    input  logic [VAR_W-1:0] s_precondition_var,
    input  logic             s_first_of_action,
    input  logic             s_last_of_action,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_applicable,
    input  tbl_view_t        view,
    output logic [IDX_W-1:0] tbl_rd_idx,
    output logic [VAR_W-1:0] pre_var,
    input  logic             bm_true_q,
    input  logic             bm_false_q,
    output bm_req_t          bm_req
);

    localparam int TBL_DEPTH = (NUM_INVARIANTS < (1 << IDX_W)) ? NUM_INVARIANTS
                                                              : (1 << IDX_W);
    localparam int BMP_DEPTH = (NUM_VARS < (1 << VAR_W)) ? NUM_VARS : (1 << VAR_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_DEPTH - 1);
    localparam logic [VAR_W-1:0] BMP_LAST = VAR_W'(BMP_DEPTH - 1);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [VAR_W-1:0] clr_reg, clr_next;
    logic [VAR_W-1:0] pre_reg, pre_next;
    logic             last_reg, last_next;
    logic             conflict_reg, conflict_next;
    logic             sel_b_reg, sel_b_next;
    logic             pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_applicable_reg, m_applicable_next;

    logic             accept;
    logic [LIT_W-1:0] inf_lit;
    logic [VAR_W-1:0] inf_var;
    logic             inf_in_range;
    logic             inf_hit;
    logic             pre_in_range;
    logic             scan_last;
    logic             out_free;

    assign accept       = s_valid && s_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign inf_lit      = sel_b_reg ? view.lit_b : view.lit_a;
    assign inf_var      = lit_var(inf_lit);
    assign inf_in_range = (32'(inf_var) < NUM_VARS);
    assign inf_hit      = inf_in_range && (lit_neg(inf_lit) ? bm_true_q : bm_false_q);
    assign pre_in_range = (32'(pre_reg) < NUM_VARS);
    assign scan_last    = (idx_reg == LAST_IDX);
    assign out_free     = !m_valid_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_action)
                        ACT_PRECOND: begin
                            if (s_first_of_action) begin
                                state_next = ST_CLEAR;
                            end else if (conflict_reg) begin
                                state_next = ST_FINISH;
                            end else begin
                                state_next = ST_SET_PRE;
                            end
                        end
                        ACT_EMPTY: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                if (clr_reg == BMP_LAST) begin
                    case (op_reg)
                        OP_PRE:   state_next = ST_SET_PRE;
                        OP_EMPTY: state_next = ST_FINISH;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SET_PRE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (view.match_a || view.match_b) begin
                    state_next = ST_INF_RD;
                end else if (scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_INF_RD: state_next = ST_INF_WR;
            ST_INF_WR: begin
                if (inf_hit) begin
                    state_next = ST_FINISH;
                end else if (sel_b_reg && pend_reg) begin
                    state_next = ST_INF_RD;
                end else if (scan_last) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_FINISH:  state_next = last_reg ? ST_RESULT : ST_IDLE;
            ST_RESULT:  state_next = out_free ? ST_IDLE : ST_RESULT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and port controls.
    always_comb begin
        op_next           = op_reg;
        idx_next          = idx_reg;
        clr_next          = clr_reg;
        pre_next          = pre_reg;
        last_next         = last_reg;
        conflict_next     = conflict_reg;
        sel_b_next        = sel_b_reg;
        pend_next         = pend_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_applicable_next = m_applicable_reg;

        bm_req.rd_addr  = inf_var;
        bm_req.wr_addr  = inf_var;
        bm_req.wr_true  = 1'b0;
        bm_req.wr_false = 1'b0;
        bm_req.wr_val   = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                clr_next = '0;
                if (accept) begin
                    case (s_action)
                        ACT_PRECOND: begin
                            op_next   = OP_PRE;
                            pre_next  = s_precondition_var;
                            last_next = s_last_of_action;
                        end
                        ACT_EMPTY: begin
                            op_next   = OP_EMPTY;
                            last_next = 1'b1;
                        end
                        default: op_next = op_reg;
                    endcase
                end
            end
            ST_CLEAR: begin
                // Sweep both bitmaps to zero and drop the sticky conflict.
                bm_req.wr_addr  = clr_reg;
                bm_req.wr_true  = 1'b1;
                bm_req.wr_false = 1'b1;
                bm_req.wr_val   = 1'b0;
                conflict_next   = 1'b0;
                clr_next        = clr_reg + 1'b1;
            end
            ST_SET_PRE: begin
                // Mark the precondition true and prefetch the first entry.
                bm_req.wr_addr = pre_reg;
                bm_req.wr_true = pre_in_range;
                idx_next       = '0;
            end
            ST_SCAN: begin
                if (view.match_a) begin
                    sel_b_next = 1'b1;
                    pend_next  = view.match_b;
                end else if (view.match_b) begin
                    sel_b_next = 1'b0;
                    pend_next  = 1'b0;
                end else if (!scan_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_INF_WR: begin
                // Set the inferred literal's bit and check the opposite bit.
                bm_req.wr_true  = inf_in_range && !lit_neg(inf_lit);
                bm_req.wr_false = inf_in_range && lit_neg(inf_lit);
                if (inf_hit) begin
                    conflict_next = 1'b1;
                end else if (sel_b_reg && pend_reg) begin
                    sel_b_next = 1'b0;
                    pend_next  = 1'b0;
                end else if (!scan_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_applicable_next = !conflict_reg;
                end
            end
            default: op_next = op_reg;
        endcase
    end

    assign tbl_rd_idx   = idx_next;
    assign pre_var      = pre_reg;
    assign m_valid      = m_valid_reg;
    assign m_applicable = m_applicable_reg;

    // Control state; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            op_reg       <= OP_NONE;
            clr_reg      <= '0;
            conflict_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            clr_reg      <= clr_next;
            conflict_reg <= conflict_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload and scan position.
    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        pre_reg          <= pre_next;
        last_reg         <= last_next;
        sel_b_reg        <= sel_b_next;
        pend_reg         <= pend_next;
        m_applicable_reg <= m_applicable_next;
    end

endmodule

// File: hw/rtl/invariant_precondition_conflict_check.sv
// -----------------------------------------------------------------------------
// invariant_precondition_conflict_check
// Checks an action's preconditions against a table of two-literal invariants.
// -----------------------------------------------------------------------------
// Input channel (s_*): one word per handshake. A write word (action 0) loads
// one invariant slot and leaves the block ready. A precondition word
// (action 1) sets its variable true if it is below NUM_VARS and scans the
// table slots in order, one slot per cycle while no literal is inferred,
// through the single table read port, up to the last slot or to a conflict.
// A precondition word marked first of action first clears every entry of
// both bitmaps (at most 1024 each) through the bitmap write ports. An empty
// action (action 2) clears and then returns applicable. Once a conflict is
// seen, the remaining words of the action skip the scan.
// Result channel (m_*): one word after the last precondition of an action or
// after an empty action; applicable is 0 when a conflict was inferred.
// One item is in work at a time; s_ready is high only while idle.
// The result sits in an output register, so a new item is taken while it
// waits; a held result stalls only the next item that has a result to give.
// Reset: a bitmap clearing pass runs with s_ready low. The invariant table is
// not cleared: the user must write every slot before use, unenforced here.
// -----------------------------------------------------------------------------
module invariant_precondition_conflict_check
    import ipcc_pkg::*;
#(
    parameter int NUM_VARS       = DEF_NUM_VARS,
    parameter int NUM_INVARIANTS = DEF_NUM_INVARIANTS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ACT_W-1:0]        s_action,
    input  logic [IDX_W-1:0]        s_entry_index,
    input  logic signed [LIT_W-1:0] s_first_literal,
    input  logic signed [LIT_W-1:0] s_second_literal,
    input  logic                    s_entry_deleted,
    input  logic [VAR_W-1:0]        s_precondition_var,
    input  logic                    s_first_of_action,
    input  logic                    s_last_of_action,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_applicable
);

    tbl_view_t        view;
    tbl_entry_t       wr_entry;
    logic             tbl_wr;
    logic [IDX_W-1:0] tbl_rd_idx;
    logic [VAR_W-1:0] pre_var;
    bm_req_t          bm_req;
    logic             bm_true_q;
    logic             bm_false_q;

    // Load table slots straight from accepted write words.
    assign tbl_wr         = s_valid && s_ready && (s_action == ACT_WRITE);
    assign wr_entry.lit_a = $unsigned(s_first_literal);
    assign wr_entry.lit_b = $unsigned(s_second_literal);
    assign wr_entry.dead  = s_entry_deleted;

    ipcc_table #(
        .NUM_INVARIANTS (NUM_INVARIANTS)
    ) u_table (
        .aclk     (aclk),
        .wr_en    (tbl_wr),
        .wr_idx   (s_entry_index),
        .wr_entry (wr_entry),
        .rd_idx   (tbl_rd_idx),
        .pre_var  (pre_var),
        .view     (view)
    );

    ipcc_bitmap #(
        .NUM_VARS (NUM_VARS)
    ) u_bitmap (
        .aclk    (aclk),
        .req     (bm_req),
        .true_q  (bm_true_q),
        .false_q (bm_false_q)
    );

    ipcc_seq #(
        .NUM_VARS       (NUM_VARS),
        .NUM_INVARIANTS (NUM_INVARIANTS)
    ) u_seq (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_precondition_var (s_precondition_var),
        .s_first_of_action  (s_first_of_action),
        .s_last_of_action   (s_last_of_action),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_applicable       (m_applicable),
        .view               (view),
        .tbl_rd_idx         (tbl_rd_idx),
        .pre_var            (pre_var),
        .bm_true_q          (bm_true_q),
        .bm_false_q         (bm_false_q),
        .bm_req             (bm_req)
    );

endmodule

// File: hw/rtl/ipcc_checker.sv
// -----------------------------------------------------------------------------
// ipcc_checker
// Port-level checks of the conflict check, bound to the top level.
// -----------------------------------------------------------------------------
`include "invariant_precondition_conflict_check_assert.svh"

module ipcc_checker
    import ipcc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [ACT_W-1:0] s_action,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_applicable
);

    // Reset starts the clearing pass, so no word is taken right after it.
    `IPCC_ASSERT_NEXT_ALWAYS(a_reset_busy, aclk, !aresetn, !s_ready)

    // An accepted precondition or empty action makes the block busy, so s_ready drops.
    `IPCC_ASSERT_NEXT(a_work_busy, aclk, aresetn,
        s_valid && s_ready && (s_action == ACT_PRECOND || s_action == ACT_EMPTY),
        !s_ready)

    // Table writes and unused codes keep the block ready.
    `IPCC_ASSERT_NEXT(a_write_ready, aclk, aresetn,
        s_valid && s_ready && !(s_action == ACT_PRECOND || s_action == ACT_EMPTY),
        s_ready)

    // A stalled result word holds.
    `IPCC_ASSERT_NEXT(a_result_hold, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_applicable))

endmodule

bind invariant_precondition_conflict_check ipcc_checker u_ipcc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_action     (s_action),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_applicable (m_applicable)
);
